// ----- rtl/indexed_queue_store_assert.svh -----
// ---------------------------------------------------------------------------
// indexed_queue_store assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef INDEXED_QUEUE_STORE_ASSERT_SVH
`define INDEXED_QUEUE_STORE_ASSERT_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge out of reset
`define IQS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("iqs check failed");

// cond at one edge implies prop at the next edge
`define IQS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("iqs check failed");

`else

`define IQS_ASSERT(label, clk, rst_n, prop)
`define IQS_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ----- rtl/iqs_pkg.sv -----
// ---------------------------------------------------------------------------
// iqs_pkg
// Shared sizes, operation and status codes, and the cell control bundle.
// ---------------------------------------------------------------------------
package iqs_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int POS_W  = 5;
    localparam int FILL_W = 5;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // transaction kinds
    localparam logic [1:0] KIND_ENQ = 2'd0;
    localparam logic [1:0] KIND_DEQ = 2'd1;
    localparam logic [1:0] KIND_INS = 2'd2;
    localparam logic [1:0] KIND_REM = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_POS   = 2'd3;

    // per-cell shift commands
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] slot;
    } cell_ctrl_t;

endpackage

// ----- rtl/iqs_cell.sv -----
// ---------------------------------------------------------------------------
// iqs_cell
// One queue slot. Opens a gap (takes the left neighbor) on insert and
// closes a gap (takes the right neighbor) on remove.
// ---------------------------------------------------------------------------
module iqs_cell
    import iqs_pkg::*;
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic [IDX_W-1:0] idx,
    input  word_t            word_in,
    input  word_t            left,
    input  word_t            right,
    output word_t            entry
);

    word_t entry_reg;
    word_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_INS:
            begin
                if (idx > ctrl.slot)
                begin
                    entry_next = left;
                end
                else if (idx == ctrl.slot)
                begin
                    entry_next = word_in;
                end
            end
            CELL_DEL:
            begin
                if (idx >= ctrl.slot)
                begin
                    entry_next = right;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- rtl/indexed_queue_store.sv -----
// ---------------------------------------------------------------------------
// indexed_queue_store
// Bounded queue of 32-bit words with positional insert and remove.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries kind, value and position.
//   Output channel (out_valid/out_ready) returns one transaction per input:
//   value_out, status, is_empty and fill_count after the operation.
//   Storage is a row of DEPTH cells, slot 0 at the head; every cell
//   shifts left, right or holds in the same cycle, so any operation
//   updates the whole row at once.
//   Latency: result valid the cycle after the input is accepted.
//   Throughput: one transaction per cycle if results are taken; the output
//   register is the only stage: in_ready is high whenever it is empty or draining.
//   Receiver stall: the result is held and in_ready drops until taken.
//   Reset: fill count goes to zero, no result pending. Slot contents are
//   not cleared; only slots below the fill count are ever read.
//   Failed operations (full, empty, bad position) leave the queue as is.
// ---------------------------------------------------------------------------
`include "indexed_queue_store_assert.svh"

module indexed_queue_store
    import iqs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               kind,
    input  logic signed [WORD_W-1:0] value,
    input  logic [POS_W-1:0]         position,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] value_out,
    output logic [1:0]               status,
    output logic                     is_empty,
    output logic [FILL_W-1:0]        fill_count
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    word_t             value_out_reg;
    logic [1:0]        status_reg;
    logic              is_empty_reg;
    logic [FILL_W-1:0] fill_reg;

    word_t             entries [DEPTH];
    cell_ctrl_t        ctrl;
    cell_ctrl_t        cell_ctrl;
    logic [1:0]        status_next;
    word_t             removed;
    logic              in_accept;
    logic              full;
    logic              empty;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);

    always_comb
    begin
        status_next = ST_OK;
        removed     = '0;
        ctrl.op     = CELL_HOLD;
        ctrl.slot   = '0;
        count_next  = count_reg;
        unique case (kind)
            KIND_ENQ:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.op    = CELL_INS;
                    ctrl.slot  = IDX_W'(count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_DEQ:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ctrl.op    = CELL_DEL;
                    ctrl.slot  = '0;
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_INS:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    status_next = ST_POS;
                end
                else
                begin
                    ctrl.op    = CELL_INS;
                    ctrl.slot  = IDX_W'(cnt_ext - pos_ext);
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_REM:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    status_next = ST_POS;
                end
                else
                begin
                    ctrl.op    = CELL_DEL;
                    ctrl.slot  = IDX_W'(cnt_ext - pos_ext - 1'b1);
                    count_next = count_reg - 1'b1;
                end
            end
        endcase
        if (ctrl.op == CELL_DEL)
        begin
            removed = entries[ctrl.slot];
        end
    end

    // cells only move on an accepted transaction
    always_comb
    begin
        cell_ctrl = ctrl;
        if (!in_accept)
        begin
            cell_ctrl.op = CELL_HOLD;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            word_t left_w;
            word_t right_w;
            if (gi == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = entries[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = entries[gi+1];
            end
            iqs_cell u_cell (
                .clk     (clk),
                .ctrl    (cell_ctrl),
                .idx     (IDX_W'(gi)),
                .word_in (value),
                .left    (left_w),
                .right   (right_w),
                .entry   (entries[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            value_out_reg <= removed;
            status_reg    <= status_next;
            is_empty_reg  <= (count_next == '0);
            fill_reg      <= FILL_W'(count_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign value_out  = value_out_reg;
    assign status     = status_reg;
    assign is_empty   = is_empty_reg;
    assign fill_count = fill_reg;

    `IQS_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `IQS_ASSERT(a_fill_tracks, clk, rst_n, !out_valid_reg || fill_reg == FILL_W'(count_reg))
    `IQS_ASSERT(a_empty_flag, clk, rst_n, !out_valid_reg || is_empty_reg == (count_reg == '0))
    `IQS_ASSERT_NEXT(a_fail_holds, clk, rst_n, in_accept && status_next != ST_OK,
        count_reg == $past(count_reg))
    `IQS_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid_reg && !out_ready,
        out_valid_reg && $stable(count_reg))

endmodule

// ----- verif/tb.sv -----
// ---------------------------------------------------------------------------
// tb: indexed_queue_store testbench
// Drives enqueue, dequeue, positional insert and remove transactions and
// checks every result against a shadow queue kept in the testbench.
// ---------------------------------------------------------------------------
module tb
    import iqs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT    = 40000;  // cycles before the run is abandoned
    localparam int HOLD_AT  = 120;    // receiver starts its long hold-off here
    localparam int HOLD_LEN = 80;
    localparam int QUIET_LO = 400;    // window with no idling on either side
    localparam int QUIET_HI = 750;
    localparam int N_RANDOM = 700;

    typedef struct {
        logic [1:0]              kind;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]        position;
    } queue_op_t;

    typedef struct {
        logic signed [WORD_W-1:0] value_out;
        logic [1:0]              status;
        logic                    is_empty;
        logic [FILL_W-1:0]       fill_count;
    } queue_result_t;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic [1:0]               kind       = KIND_ENQ;
    logic signed [WORD_W-1:0] value      = '0;
    logic [POS_W-1:0]         position   = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic signed [WORD_W-1:0] value_out;
    logic [1:0]               status;
    logic                     is_empty;
    logic [FILL_W-1:0]        fill_count;

    queue_op_t     pending_ops[$];
    queue_result_t expected_results[$];

    // shadow of the store, slot 0 at the head
    logic signed [WORD_W-1:0] shadow_words [DEPTH];
    int                       shadow_count = 0;

    int  gen_count = 0;   // fill level as the stimulus generator sees it
    int  cyc       = 0;
    int  err_cnt   = 0;
    int  hold_left = 0;
    logic quiet;

    assign quiet = (cyc >= QUIET_LO) && (cyc < QUIET_HI);

    indexed_queue_store u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value_out  (value_out),
        .status     (status),
        .is_empty   (is_empty),
        .fill_count (fill_count)
    );

    always #5 clk = ~clk;

    function automatic void shadow_put(int slot, logic signed [WORD_W-1:0] word);
        for (int i = shadow_count; i > slot; i--)
            shadow_words[i] = shadow_words[i-1];
        shadow_words[slot] = word;
        shadow_count++;
    endfunction

    function automatic logic signed [WORD_W-1:0] shadow_take(int slot);
        logic signed [WORD_W-1:0] word;
        word = shadow_words[slot];
        for (int i = slot; i + 1 < shadow_count; i++)
            shadow_words[i] = shadow_words[i+1];
        shadow_count--;
        return word;
    endfunction

    function automatic queue_result_t apply_queue_op(logic [1:0] op_kind,
                                                     logic signed [WORD_W-1:0] word,
                                                     logic [POS_W-1:0] pos);
        queue_result_t r;
        int            p;
        p = int'(pos);
        r.value_out = '0;
        r.status    = ST_OK;
        case (op_kind)
            KIND_ENQ:
                if (shadow_count >= DEPTH) r.status = ST_FULL;
                else shadow_put(shadow_count, word);
            KIND_DEQ:
                if (shadow_count == 0) r.status = ST_EMPTY;
                else r.value_out = shadow_take(0);
            KIND_INS:
                if (shadow_count >= DEPTH) r.status = ST_FULL;
                else if (p > shadow_count) r.status = ST_POS;
                else shadow_put(shadow_count - p, word);
            default:
                if (shadow_count == 0) r.status = ST_EMPTY;
                else if (p >= shadow_count) r.status = ST_POS;
                else r.value_out = shadow_take(shadow_count - 1 - p);
        endcase
        r.is_empty   = (shadow_count == 0);
        r.fill_count = shadow_count[FILL_W-1:0];
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // queue a transaction and track the fill level it leads to
    function automatic void add_op(logic [1:0] k, logic signed [WORD_W-1:0] v, int p);
        queue_op_t t;
        t.kind     = k;
        t.value    = v;
        t.position = p[POS_W-1:0];
        pending_ops.push_back(t);
        case (k)
            KIND_ENQ: if (gen_count < DEPTH) gen_count++;
            KIND_DEQ: if (gen_count > 0) gen_count--;
            KIND_INS: if (gen_count < DEPTH && p <= gen_count) gen_count++;
            default:  if (gen_count > 0 && p < gen_count) gen_count--;
        endcase
    endfunction

    initial
    begin : stimulus
        int         phase_left;
        int         mode;
        int         pick;
        int         p;
        logic [1:0] k;

        // directed: empty, bad positions, head/tail/middle, word extremes
        add_op(KIND_DEQ, 32'sd0, 0);
        add_op(KIND_REM, 32'sd0, 0);
        add_op(KIND_INS, 32'sd5, 1);
        add_op(KIND_INS, 32'sh7FFF_FFFF, 0);
        add_op(KIND_ENQ, 32'sh8000_0000, 0);
        add_op(KIND_INS, -32'sd1, 2);
        add_op(KIND_INS, 32'sd123, 1);
        add_op(KIND_INS, 32'sd9, 5);
        add_op(KIND_REM, 32'sd0, 4);
        add_op(KIND_REM, 32'sd0, 31);
        add_op(KIND_INS, 32'sd0, 31);
        add_op(KIND_REM, 32'sd0, 3);
        add_op(KIND_REM, 32'sd0, 0);
        add_op(KIND_DEQ, 32'sd0, 0);
        add_op(KIND_DEQ, 32'sd0, 0);
        add_op(KIND_DEQ, 32'sd0, 0);

        // random phases: fill-heavy, drain-heavy or mixed
        mode       = 0;
        phase_left = 40;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (phase_left == 0)
            begin
                mode       = $urandom_range(0, 2);
                phase_left = $urandom_range(15, 40);
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            case (mode)
                0:       k = (pick < 45) ? KIND_ENQ : (pick < 90) ? KIND_INS :
                             (pick < 95) ? KIND_DEQ : KIND_REM;
                1:       k = (pick < 45) ? KIND_DEQ : (pick < 90) ? KIND_REM :
                             (pick < 95) ? KIND_ENQ : KIND_INS;
                default: k = 2'(pick / 25);
            endcase
            if (k == KIND_INS && $urandom_range(0, 99) < 85)
                p = $urandom_range(0, gen_count);
            else if (k == KIND_REM && gen_count > 0 && $urandom_range(0, 99) < 85)
                p = $urandom_range(0, gen_count - 1);
            else
                p = $urandom_range(0, 31);
            add_op(k, rand_word(), p);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_valid) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (err_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // sender: holds each transaction until accepted, predicts on acceptance
    always @(posedge clk)
    begin : op_driver
        queue_op_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(apply_queue_op(kind, value, position));
            if (!in_valid || in_ready)
            begin
                if (pending_ops.size() != 0 && (quiet || $urandom_range(0, 99) >= 6))
                begin
                    nxt = pending_ops.pop_front();
                    in_valid <= 1'b1;
                    kind     <= nxt.kind;
                    value    <= nxt.value;
                    position <= nxt.position;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back up the input
    always @(posedge clk)
    begin : result_sink
        if (!rst_n)
            out_ready <= 1'b0;
        else if (cyc == HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= quiet || ($urandom_range(0, 99) >= 6);
    end

    always @(posedge clk)
    begin : result_check
        queue_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                err_cnt++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (value_out !== want.value_out)
                begin
                    $error("value_out: expected %0d, got %0d", want.value_out, value_out);
                    err_cnt++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    err_cnt++;
                end
                if (is_empty !== want.is_empty)
                begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
                    err_cnt++;
                end
                if (fill_count !== want.fill_count)
                begin
                    $error("fill_count: expected %0d, got %0d", want.fill_count, fill_count);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cyc <= cyc + 1;
        if (cyc == LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule

// ----- indexed_queue_store.f -----
+incdir+rtl
rtl/iqs_pkg.sv
rtl/iqs_cell.sv
rtl/indexed_queue_store.sv
verif/tb.sv
